@@ hw/rtl/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the linear key/value table
// Operation and status codes, fixed port widths and the per-cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

    localparam int KIND_W       = 2;
    localparam int KEY_PORT_W   = 32;
    localparam int VAL_PORT_W   = 32;
    localparam int INDEX_W      = 4;
    localparam int STATUS_W     = 2;
    localparam int COUNT_PORT_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_GET    = 2'd0,
        KIND_PUT    = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Control word driven to each cell of the chain.
    typedef struct packed {
        logic compare;      // register the match result this cycle
        logic by_position;  // match on the cell position instead of the key
        logic load;         // take the write key and value
        logic shift;        // take the entry of the next cell up
    } cell_ctrl_t;

endpackage : lkv_pkg

`default_nettype wire

@@ hw/rtl/lkv_cell.sv @@
// ----------------------------------------------------------------------------
// lkv_cell: one entry of the table
// Holds a key and a value, compares them against the search key or its own
// position, and can load a new entry or take the entry of its upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cell #(
    parameter int INDEX = 0,
    parameter int KEY_W = 32,
    parameter int VAL_W = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire lkv_pkg::cell_ctrl_t         ctrl,
    input  wire logic                        active,
    input  wire logic [KEY_W-1:0]            cmp_key,
    input  wire logic [lkv_pkg::INDEX_W-1:0] cmp_idx,
    input  wire logic [KEY_W-1:0]            wr_key,
    input  wire logic [VAL_W-1:0]            wr_val,
    input  wire logic [KEY_W-1:0]            nb_key,
    input  wire logic [VAL_W-1:0]            nb_val,
    output logic      [KEY_W-1:0]            key,
    output logic      [VAL_W-1:0]            val,
    output logic                             hit
);

    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic             hit_reg;
    logic             hit_next;

    always_comb begin
        if (ctrl.by_position) begin
            hit_next = active && (32'(cmp_idx) == INDEX);
        end else begin
            hit_next = active && (key_reg == cmp_key);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (ctrl.compare) begin
            hit_reg <= hit_next;
        end
    end

    // Entry storage carries no reset; only positions below the count are read.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            key_reg <= wr_key;
            val_reg <= wr_val;
        end else if (ctrl.shift) begin
            key_reg <= nb_key;
            val_reg <= nb_val;
        end
    end

    assign key = key_reg;
    assign val = val_reg;
    assign hit = hit_reg;

endmodule : lkv_cell

`default_nettype wire

@@ hw/rtl/lkv_select.sv @@
// ----------------------------------------------------------------------------
// lkv_select: match resolution
// Turns the registered one-hot hit vector of the chain into a found flag, the
// matching position and the key and value held there, all registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_select #(
    parameter int DEPTH = 16,
    parameter int KEY_W = 32,
    parameter int VAL_W = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [DEPTH-1:0]              hit,
    input  wire logic [DEPTH-1:0][KEY_W-1:0]   keys,
    input  wire logic [DEPTH-1:0][VAL_W-1:0]   vals,
    output logic                               found,
    output logic      [$clog2(DEPTH)-1:0]      pos,
    output logic      [KEY_W-1:0]              sel_key,
    output logic      [VAL_W-1:0]              sel_val
);

    localparam int IDX_W = $clog2(DEPTH);

    logic             found_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [IDX_W-1:0] pos_next;
    logic [KEY_W-1:0] key_next;
    logic [VAL_W-1:0] val_next;

    // At most one hit is set, so an OR over the gated entries is a mux.
    always_comb begin
        pos_next = '0;
        key_next = '0;
        val_next = '0;
        for (int i = 0; i < DEPTH; i++) begin
            pos_next = pos_next | (hit[i] ? IDX_W'(i) : '0);
            key_next = key_next | (hit[i] ? keys[i] : '0);
            val_next = val_next | (hit[i] ? vals[i] : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= |hit;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        key_reg <= key_next;
        val_reg <= val_next;
    end

    assign found   = found_reg;
    assign pos     = pos_reg;
    assign sel_key = key_reg;
    assign sel_val = val_reg;

endmodule : lkv_select

`default_nettype wire

@@ hw/rtl/linear_key_value_table.sv @@
// ----------------------------------------------------------------------------
// linear_key_value_table: fixed-capacity key/value table in insertion order
// A chain of entry cells searched in parallel; remove shifts entries down.
// ----------------------------------------------------------------------------
// The s_ channel carries one operation per beat: get, put, remove or read at
// an index. The m_ channel returns one result beat per operation with a
// status, the found or previous value, the key for read-at-index and the
// entry count after the operation.
// After the edge that accepts the operation, the cells compare against the key
// or position and register the match, the select block resolves the match and
// registers it, and the apply state updates the table and loads the result
// register. The input is ready again only after the apply, so a new operation
// is accepted only once the previous one has been applied.
// The result sits in an output register, so a new operation is accepted while
// the previous result still waits. If the receiver stalls, the next operation
// waits in its final cycle until the output register frees up.
// Reset empties the table (count zero) and drops any pending result; no
// clearing pass is needed because entries above the count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_key_value_table #(
    parameter int DEPTH = 16,
    parameter int KEY_W = 32,
    parameter int VAL_W = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [lkv_pkg::KIND_W-1:0]       s_kind,
    input  wire logic [lkv_pkg::KEY_PORT_W-1:0]   s_key,
    input  wire logic [lkv_pkg::VAL_PORT_W-1:0]   s_value,
    input  wire logic [lkv_pkg::INDEX_W-1:0]      s_index,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [lkv_pkg::STATUS_W-1:0]     m_status,
    output logic      [lkv_pkg::VAL_PORT_W-1:0]   m_value_out,
    output logic      [lkv_pkg::KEY_PORT_W-1:0]   m_key_out,
    output logic      [lkv_pkg::COUNT_PORT_W-1:0] m_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_APPLY
    } state_t;

    state_t                            state_reg;
    lkv_pkg::kind_t                    kind_reg;
    logic [KEY_W-1:0]                  op_key_reg;
    logic [VAL_W-1:0]                  op_val_reg;
    logic [lkv_pkg::INDEX_W-1:0]       op_idx_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;

    logic                              m_valid_reg;
    logic [lkv_pkg::STATUS_W-1:0]      status_reg;
    logic [lkv_pkg::VAL_PORT_W-1:0]    value_out_reg;
    logic [lkv_pkg::KEY_PORT_W-1:0]    key_out_reg;
    lkv_pkg::status_t                  status_next;
    logic [VAL_W-1:0]                  value_res;
    logic [KEY_W-1:0]                  key_res;

    logic [KEY_W-1:0]                  in_key;
    logic [VAL_W-1:0]                  in_val;
    logic [lkv_pkg::VAL_PORT_W-1:0]    value_port;
    logic [lkv_pkg::KEY_PORT_W-1:0]    key_port;

    logic [DEPTH-1:0]                  hit_vec;
    logic [DEPTH-1:0][KEY_W-1:0]       keys;
    logic [DEPTH-1:0][VAL_W-1:0]       vals;
    lkv_pkg::cell_ctrl_t [DEPTH-1:0]   cell_ctrl;
    logic [DEPTH-1:0]                  active;

    logic                              found;
    logic [IDX_W-1:0]                  pos;
    logic [KEY_W-1:0]                  sel_key;
    logic [VAL_W-1:0]                  sel_val;

    logic                              s_fire;
    logic                              fire;
    logic                              full;

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign fire    = (state_reg == S_APPLY) && (!m_valid_reg || m_ready);
    assign full    = (32'(count_reg) == DEPTH);

    // Fit the fixed port fields to the configured key and value widths.
    generate
        if (KEY_W <= lkv_pkg::KEY_PORT_W) begin : g_key_narrow
            assign in_key   = s_key[KEY_W-1:0];
            assign key_port = {{(lkv_pkg::KEY_PORT_W - KEY_W){1'b0}}, key_res};
        end else begin : g_key_wide
            assign in_key   = {{(KEY_W - lkv_pkg::KEY_PORT_W){1'b0}}, s_key};
            assign key_port = key_res[lkv_pkg::KEY_PORT_W-1:0];
        end
        if (VAL_W <= lkv_pkg::VAL_PORT_W) begin : g_val_narrow
            assign in_val     = s_value[VAL_W-1:0];
            assign value_port = {{(lkv_pkg::VAL_PORT_W - VAL_W){1'b0}}, value_res};
        end else begin : g_val_wide
            assign in_val     = {{(VAL_W - lkv_pkg::VAL_PORT_W){1'b0}}, s_value};
            assign value_port = value_res[lkv_pkg::VAL_PORT_W-1:0];
        end
        if (CNT_W <= lkv_pkg::COUNT_PORT_W) begin : g_cnt_narrow
            assign m_count = {{(lkv_pkg::COUNT_PORT_W - CNT_W){1'b0}}, count_reg};
        end else begin : g_cnt_wide
            assign m_count = count_reg[lkv_pkg::COUNT_PORT_W-1:0];
        end
    endgenerate

    // Per-cell control: compare in S_CMP, load or shift only on the apply beat.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            active[i]                = (32'(count_reg) > i);
            cell_ctrl[i].compare     = (state_reg == S_CMP);
            cell_ctrl[i].by_position = (kind_reg == lkv_pkg::KIND_READ);
            cell_ctrl[i].load        = fire && (kind_reg == lkv_pkg::KIND_PUT) &&
                                       ((found && (32'(pos) == i)) ||
                                        (!found && !full && (32'(count_reg) == i)));
            cell_ctrl[i].shift       = fire && (kind_reg == lkv_pkg::KIND_REMOVE) &&
                                       found && (32'(pos) <= i);
        end
    end

    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic [KEY_W-1:0] nb_key;
            logic [VAL_W-1:0] nb_val;
            if (g == DEPTH - 1) begin : g_top
                assign nb_key = keys[g];
                assign nb_val = vals[g];
            end else begin : g_mid
                assign nb_key = keys[g+1];
                assign nb_val = vals[g+1];
            end
            lkv_cell #(
                .INDEX (g),
                .KEY_W (KEY_W),
                .VAL_W (VAL_W)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (cell_ctrl[g]),
                .active  (active[g]),
                .cmp_key (op_key_reg),
                .cmp_idx (op_idx_reg),
                .wr_key  (op_key_reg),
                .wr_val  (op_val_reg),
                .nb_key  (nb_key),
                .nb_val  (nb_val),
                .key     (keys[g]),
                .val     (vals[g]),
                .hit     (hit_vec[g])
            );
        end
    endgenerate

    lkv_select #(
        .DEPTH (DEPTH),
        .KEY_W (KEY_W),
        .VAL_W (VAL_W)
    ) u_select (
        .aclk    (aclk),
        .aresetn (aresetn),
        .hit     (hit_vec),
        .keys    (keys),
        .vals    (vals),
        .found   (found),
        .pos     (pos),
        .sel_key (sel_key),
        .sel_val (sel_val)
    );

    always_comb begin
        status_next = lkv_pkg::ST_MISS;
        value_res   = '0;
        key_res     = '0;
        count_next  = count_reg;
        case (kind_reg)
            lkv_pkg::KIND_GET: begin
                if (found) begin
                    status_next = lkv_pkg::ST_FOUND;
                    value_res   = sel_val;
                end
            end
            lkv_pkg::KIND_PUT: begin
                if (found) begin
                    status_next = lkv_pkg::ST_FOUND;
                    value_res   = sel_val;
                end else if (!full) begin
                    count_next  = count_reg + 1'b1;
                end else begin
                    status_next = lkv_pkg::ST_FULL;
                end
            end
            lkv_pkg::KIND_REMOVE: begin
                if (found) begin
                    status_next = lkv_pkg::ST_FOUND;
                    value_res   = sel_val;
                    count_next  = count_reg - 1'b1;
                end
            end
            lkv_pkg::KIND_READ: begin
                if (found) begin
                    status_next = lkv_pkg::ST_FOUND;
                    value_res   = sel_val;
                    key_res     = sel_key;
                end
            end
            default: begin
                status_next = lkv_pkg::ST_MISS;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // A new result loaded in the same cycle keeps the valid flag set.
            if (m_valid_reg && m_ready && !fire) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    state_reg <= S_SEL;
                end
                S_SEL: begin
                    state_reg <= S_APPLY;
                end
                S_APPLY: begin
                    if (fire) begin
                        state_reg   <= S_IDLE;
                        count_reg   <= count_next;
                        m_valid_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg   <= lkv_pkg::kind_t'(s_kind);
            op_key_reg <= in_key;
            op_val_reg <= in_val;
            op_idx_reg <= s_index;
        end
        if (fire) begin
            status_reg    <= status_next;
            value_out_reg <= value_port;
            key_out_reg   <= key_port;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_value_out = value_out_reg;
    assign m_key_out   = key_out_reg;

    // Keys are unique and positions distinct, so at most one cell may match.
    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEL) |-> $onehot0(hit_vec))
        else $error("more than one cell matched");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= DEPTH)
        else $error("entry count beyond capacity");

    a_count_only_on_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(count_reg))
        else $error("entry count changed outside the apply beat");

    a_result_after_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("applied operation produced no result beat");

    a_idle_after_apply: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after apply");

endmodule : linear_key_value_table

`default_nettype wire
